// ===== rtl/kalman_angle_bias_filter_macros.svh =====
// Assertion macros for the angle/bias filter checker.
`ifndef KALMAN_ANGLE_BIAS_FILTER_MACROS_SVH
`define KALMAN_ANGLE_BIAS_FILTER_MACROS_SVH

// same-cycle implication
`define KABF_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define KABF_ASSERT_NXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/kabf_pkg.sv =====
// Types, constants and helpers for the angle/bias Kalman filter.
package kabf_pkg;

  localparam int unsigned DATA_W = 32;
  localparam int unsigned DT_W   = 24;
  localparam int unsigned CFG_IDX_W = 2;

  localparam logic [31:0] ANGLE_PN_RST = 32'd4294967;
  localparam logic [31:0] BIAS_PN_RST  = 32'd12884902;
  localparam logic [31:0] MEAS_N_RST   = 32'd128849019;

  localparam logic [CFG_IDX_W-1:0] REG_ANGLE_PN = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_BIAS_PN  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_MEAS_N   = 2'd2;

  localparam logic KIND_UPDATE = 1'b0;
  localparam logic KIND_SET    = 1'b1;

  localparam logic signed [31:0] SAT_MAX = 32'sh7fffffff;
  localparam logic signed [31:0] SAT_MIN = 32'sh80000000;

  typedef struct packed {
    logic                     kind;
    logic signed [DATA_W-1:0] measured_angle;
    logic signed [DATA_W-1:0] measured_rate;
    logic [DT_W-1:0]          time_step;
  } in_t;

  typedef struct packed {
    logic signed [DATA_W-1:0] filtered_angle;
    logic signed [DATA_W-1:0] unbiased_rate;
    logic signed [DATA_W-1:0] bias_estimate;
  } out_t;

  typedef enum logic [4:0] {
    ST_IDLE, ST_MUL_RATE, ST_PRED, ST_DP11, ST_INNER, ST_MUL_INNER, ST_P00, ST_P11,
    ST_DIV_SET, ST_DIV_RUN, ST_DIV_END, ST_K0Y, ST_K1Y, ST_K0P00, ST_K0P01, ST_K1P00,
    ST_K1P01, ST_FIN
  } state_e;

  // clamp a 48-bit signed value to 32 bits
  function automatic logic signed [31:0] sat32(input logic signed [47:0] v);
    logic signed [31:0] r;
    if (v > 48'(SAT_MAX))      r = SAT_MAX;
    else if (v < 48'(SAT_MIN)) r = SAT_MIN;
    else                       r = v[31:0];
    return r;
  endfunction

endpackage

// ===== rtl/kalman_angle_bias_filter.sv =====
// Two-state angle/gyro-bias Kalman filter on one shared multiplier and divider.
// Each update item runs two 32-step restoring divisions for the gains (skipped when a gain
//   saturates or its divisor is zero); a set-angle item goes straight to the result state.
//   A stalled output holds the block in the result state until the receiver takes the item.
// One item at a time: ready is low from accept until the result is registered.
// Reset: asynchronous, active low; estimates and covariance clear to zero,
//   noise registers return to their defaults.
module kalman_angle_bias_filter (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_ready_o,
  input  kabf_pkg::in_t         in_data_i,
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  output kabf_pkg::out_t        out_data_o,
  input  logic                  cfg_valid_i,
  output logic                  cfg_ready_o,
  input  logic [kabf_pkg::CFG_IDX_W-1:0] cfg_index_i,
  input  logic [31:0]           cfg_data_i
);

  kabf_pkg::state_e state_q, state_d;
  logic [31:0] apn_q, bpn_q, mn_q;
  logic signed [31:0] ang_q, ang_d, bias_q, bias_d;
  logic signed [31:0] c00_q, c00_d, c01_q, c01_d, c10_q, c10_d, c11_q, c11_d;
  kabf_pkg::in_t in_q, in_d;
  logic signed [31:0] rate_q, rate_d, pred_q, pred_d, dp11_q, dp11_d;
  logic signed [34:0] inner_q, inner_d;
  logic signed [31:0] p00_q, p00_d, p01_q, p01_d, p10_q, p10_d, p11_q, p11_d;
  logic signed [32:0] s_q, s_d;
  logic signed [31:0] y_q, y_d, k0_q, k0_d, k1_q, k1_d;
  logic gsel_q, gsel_d, dneg_q, dneg_d;
  logic [32:0] rem_q, rem_d;
  logic [31:0] quo_q, quo_d;
  logic [4:0] cnt_q, cnt_d;
  logic out_valid_q, out_valid_d;
  kabf_pkg::out_t out_q, out_d;

  // shared multiplier: sign-magnitude, product registered
  logic signed [34:0] ma;
  logic signed [32:0] mb;
  logic msh;
  logic [34:0] ma_abs;
  logic [32:0] mb_abs;
  logic [67:0] prod_q;
  logic pneg_q, psh_q;
  logic [43:0] res_mag;
  logic signed [44:0] res;
  logic signed [47:0] res_x;

  assign ma_abs = ma[34] ? 35'(-ma) : 35'(ma);
  assign mb_abs = mb[32] ? 33'(-mb) : 33'(mb);
  assign res_mag = psh_q ? {4'd0, prod_q[67:28]} : prod_q[67:24];
  assign res = pneg_q ? -$signed({1'b0, res_mag}) : $signed({1'b0, res_mag});
  assign res_x = 48'(res);

  // divider operands
  logic signed [31:0] dnum;
  logic [31:0] nmag;
  logic [59:0] nfull;
  logic [32:0] dmag;
  logic [33:0] r2;
  logic dge;
  logic signed [31:0] kval;
  logic kwr;

  assign dnum  = gsel_q ? p10_q : p00_q;
  assign nmag  = dnum[31] ? 32'(-dnum) : 32'(dnum);
  assign nfull = {nmag, 28'd0};
  assign dmag  = s_q[32] ? 33'(-s_q) : 33'(s_q);
  assign r2    = {rem_q, quo_q[31]};
  assign dge   = r2 >= {1'b0, dmag};

  assign in_ready_o  = (state_q == kabf_pkg::ST_IDLE);
  assign cfg_ready_o = 1'b1;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  always_comb begin
    state_d = state_q;
    ang_d = ang_q; bias_d = bias_q;
    c00_d = c00_q; c01_d = c01_q; c10_d = c10_q; c11_d = c11_q;
    in_d = in_q; rate_d = rate_q; pred_d = pred_q; dp11_d = dp11_q; inner_d = inner_q;
    p00_d = p00_q; p01_d = p01_q; p10_d = p10_q; p11_d = p11_q;
    s_d = s_q; y_d = y_q; k0_d = k0_q; k1_d = k1_q;
    gsel_d = gsel_q; dneg_d = dneg_q; rem_d = rem_q; quo_d = quo_q; cnt_d = cnt_q;
    out_valid_d = out_valid_q; out_d = out_q;
    ma = '0; mb = '0; msh = 1'b0;
    kval = '0; kwr = 1'b0;

    if (out_valid_q && out_ready_i) out_valid_d = 1'b0;

    unique case (state_q)
      kabf_pkg::ST_IDLE: begin
        if (in_valid_i) begin
          in_d = in_data_i;
          rate_d = kabf_pkg::sat32(48'(in_data_i.measured_rate) - 48'(bias_q));
          if (in_data_i.kind == kabf_pkg::KIND_SET) begin
            ang_d = in_data_i.measured_angle;
            state_d = kabf_pkg::ST_FIN;
          end else begin
            state_d = kabf_pkg::ST_MUL_RATE;
          end
        end
      end
      kabf_pkg::ST_MUL_RATE: begin
        ma = 35'(rate_q); mb = 33'($signed({1'b0, in_q.time_step}));
        state_d = kabf_pkg::ST_PRED;
      end
      kabf_pkg::ST_PRED: begin
        pred_d = kabf_pkg::sat32(48'(ang_q) + res_x);
        ma = 35'(c11_q); mb = 33'($signed({1'b0, in_q.time_step}));
        state_d = kabf_pkg::ST_DP11;
      end
      kabf_pkg::ST_DP11: begin
        dp11_d = res[31:0];
        state_d = kabf_pkg::ST_INNER;
      end
      kabf_pkg::ST_INNER: begin
        inner_d = 35'(dp11_q) - 35'(c01_q) - 35'(c10_q) + 35'($signed({1'b0, apn_q[31:4]}));
        p01_d = kabf_pkg::sat32(48'(c01_q) - 48'(dp11_q));
        p10_d = kabf_pkg::sat32(48'(c10_q) - 48'(dp11_q));
        state_d = kabf_pkg::ST_MUL_INNER;
      end
      kabf_pkg::ST_MUL_INNER: begin
        ma = inner_q; mb = 33'($signed({1'b0, in_q.time_step}));
        state_d = kabf_pkg::ST_P00;
      end
      kabf_pkg::ST_P00: begin
        p00_d = kabf_pkg::sat32(48'(c00_q) + res_x);
        ma = 35'($signed({1'b0, bpn_q[31:4]})); mb = 33'($signed({1'b0, in_q.time_step}));
        state_d = kabf_pkg::ST_P11;
      end
      kabf_pkg::ST_P11: begin
        p11_d = kabf_pkg::sat32(48'(c11_q) + res_x);
        s_d = 33'(p00_q) + 33'($signed({1'b0, mn_q[31:4]}));
        y_d = kabf_pkg::sat32(48'(in_q.measured_angle) - 48'(pred_q));
        gsel_d = 1'b0;
        state_d = kabf_pkg::ST_DIV_SET;
      end
      kabf_pkg::ST_DIV_SET: begin
        dneg_d = dnum[31] ^ s_q[32];
        if (dmag == '0) begin
          kval = '0; kwr = 1'b1;
        end else if ({4'd0, nfull[59:31]} >= dmag) begin
          kval = (dnum[31] ^ s_q[32]) ? kabf_pkg::SAT_MIN : kabf_pkg::SAT_MAX;
          kwr = 1'b1;
        end else begin
          rem_d = {5'd0, nfull[59:32]};
          quo_d = nfull[31:0];
          cnt_d = '0;
          state_d = kabf_pkg::ST_DIV_RUN;
        end
      end
      kabf_pkg::ST_DIV_RUN: begin
        rem_d = dge ? 33'(r2 - {1'b0, dmag}) : r2[32:0];
        quo_d = {quo_q[30:0], dge};
        cnt_d = cnt_q + 5'd1;
        if (cnt_q == 5'd31) state_d = kabf_pkg::ST_DIV_END;
      end
      kabf_pkg::ST_DIV_END: begin
        kval = dneg_q ? -$signed(quo_q) : $signed(quo_q);
        kwr = 1'b1;
      end
      kabf_pkg::ST_K0Y: begin
        ma = 35'(k0_q); mb = 33'(y_q); msh = 1'b1;
        state_d = kabf_pkg::ST_K1Y;
      end
      kabf_pkg::ST_K1Y: begin
        ang_d = kabf_pkg::sat32(48'(pred_q) + res_x);
        ma = 35'(k1_q); mb = 33'(y_q); msh = 1'b1;
        state_d = kabf_pkg::ST_K0P00;
      end
      kabf_pkg::ST_K0P00: begin
        bias_d = kabf_pkg::sat32(48'(bias_q) + res_x);
        ma = 35'(k0_q); mb = 33'(p00_q); msh = 1'b1;
        state_d = kabf_pkg::ST_K0P01;
      end
      kabf_pkg::ST_K0P01: begin
        c00_d = kabf_pkg::sat32(48'(p00_q) - res_x);
        ma = 35'(k0_q); mb = 33'(p01_q); msh = 1'b1;
        state_d = kabf_pkg::ST_K1P00;
      end
      kabf_pkg::ST_K1P00: begin
        c01_d = kabf_pkg::sat32(48'(p01_q) - res_x);
        ma = 35'(k1_q); mb = 33'(p00_q); msh = 1'b1;
        state_d = kabf_pkg::ST_K1P01;
      end
      kabf_pkg::ST_K1P01: begin
        c10_d = kabf_pkg::sat32(48'(p10_q) - res_x);
        ma = 35'(k1_q); mb = 33'(p01_q); msh = 1'b1;
        state_d = kabf_pkg::ST_FIN;
      end
      kabf_pkg::ST_FIN: begin
        // last product lands here on update items only; keep it alive while waiting
        if (in_q.kind == kabf_pkg::KIND_UPDATE) begin
          c11_d = kabf_pkg::sat32(48'(p11_q) - res_x);
          ma = 35'(k1_q); mb = 33'(p01_q); msh = 1'b1;
        end
        if (!out_valid_q || out_ready_i) begin
          out_valid_d = 1'b1;
          out_d.filtered_angle = ang_q;
          out_d.unbiased_rate  = rate_q;
          out_d.bias_estimate  = bias_q;
          state_d = kabf_pkg::ST_IDLE;
        end
      end
      default: state_d = kabf_pkg::ST_IDLE;
    endcase

    // gain write-back, then second gain or the corrections
    if (kwr) begin
      if (!gsel_q) begin
        k0_d = kval; gsel_d = 1'b1; state_d = kabf_pkg::ST_DIV_SET;
      end else begin
        k1_d = kval; state_d = kabf_pkg::ST_K0Y;
      end
    end
  end

  // FIN may wait on the output; keep c11 from being corrected twice
  logic fin_hold;
  assign fin_hold = (state_q == kabf_pkg::ST_FIN) && (state_d == kabf_pkg::ST_FIN);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= kabf_pkg::ST_IDLE;
      apn_q <= kabf_pkg::ANGLE_PN_RST;
      bpn_q <= kabf_pkg::BIAS_PN_RST;
      mn_q  <= kabf_pkg::MEAS_N_RST;
      ang_q <= '0; bias_q <= '0;
      c00_q <= '0; c01_q <= '0; c10_q <= '0; c11_q <= '0;
      out_valid_q <= 1'b0;
      gsel_q <= 1'b0;
    end else begin
      state_q <= state_d;
      ang_q <= ang_d; bias_q <= bias_d;
      c00_q <= c00_d; c01_q <= c01_d; c10_q <= c10_d;
      if (!fin_hold) c11_q <= c11_d;
      out_valid_q <= out_valid_d;
      gsel_q <= gsel_d;
      if (cfg_valid_i) begin
        unique case (cfg_index_i)
          kabf_pkg::REG_ANGLE_PN: apn_q <= cfg_data_i;
          kabf_pkg::REG_BIAS_PN:  bpn_q <= cfg_data_i;
          kabf_pkg::REG_MEAS_N:   mn_q  <= cfg_data_i;
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    in_q <= in_d; rate_q <= rate_d; pred_q <= pred_d; dp11_q <= dp11_d; inner_q <= inner_d;
    p00_q <= p00_d; p01_q <= p01_d; p10_q <= p10_d; p11_q <= p11_d;
    s_q <= s_d; y_q <= y_d; k0_q <= k0_d; k1_q <= k1_d;
    dneg_q <= dneg_d; rem_q <= rem_d; quo_q <= quo_d; cnt_q <= cnt_d;
    out_q <= out_d;
    prod_q <= 68'(ma_abs) * 68'(mb_abs);
    pneg_q <= ma[34] ^ mb[32];
    psh_q  <= msh;
  end

endmodule

// ===== rtl/kabf_checker.sv =====
// Port-level checks for the angle/bias filter, bound to the top level.
`include "kalman_angle_bias_filter_macros.svh"

module kabf_checker (
  input logic                  clk_i,
  input logic                  rst_ni,
  input logic                  in_valid_i,
  input logic                  in_ready_o,
  input logic                  out_valid_o,
  input logic                  out_ready_i,
  input kabf_pkg::out_t        out_data_o
);

  `KABF_ASSERT_NXT(a_out_hold, out_valid_o && !out_ready_i, out_valid_o && $stable(out_data_o), "result item dropped or changed while stalled")
  `KABF_ASSERT_NXT(a_busy_after_accept, in_valid_i && in_ready_o, !in_ready_o, "block ready right after accepting an item")
  `KABF_ASSERT_NOW(a_result_from_busy, $rose(out_valid_o), $past(!in_ready_o), "result appeared without an item in flight")
  `KABF_ASSERT_NXT(a_no_instant_result, in_valid_i && in_ready_o, !$rose(out_valid_o), "result in the cycle after accept")

endmodule

bind kalman_angle_bias_filter kabf_checker u_kabf_checker (.*);

// ===== dv/kabf_scoreboard.sv =====
// Scoreboard class: angle/bias filter predictor and result checker.
class kabf_scoreboard;
  logic [31:0] angle_pn, bias_pn, meas_n;
  longint angle_est, bias_est, p_aa, p_ab, p_ba, p_bb;
  kabf_pkg::out_t pending[$];
  int mismatches;

  function void reset_state();
    angle_pn = kabf_pkg::ANGLE_PN_RST;
    bias_pn = kabf_pkg::BIAS_PN_RST;
    meas_n = kabf_pkg::MEAS_N_RST;
    angle_est = 0; bias_est = 0; p_aa = 0; p_ab = 0; p_ba = 0; p_bb = 0;
    pending.delete();
    mismatches = 0;
  endfunction

  function void write_reg(logic [kabf_pkg::CFG_IDX_W-1:0] idx, logic [31:0] val);
    case (idx)
      kabf_pkg::REG_ANGLE_PN: angle_pn = val;
      kabf_pkg::REG_BIAS_PN:  bias_pn = val;
      kabf_pkg::REG_MEAS_N:   meas_n = val;
      default: ;
    endcase
  endfunction

  function longint clamp(longint v);
    if (v > 64'sd2147483647) return 64'sd2147483647;
    if (v < -64'sd2147483648) return -64'sd2147483648;
    return v;
  endfunction

  // exact product, shift truncating toward zero, magnitude capped at 2^62
  function longint mul_shift(longint a, longint b, int s);
    logic [127:0] prod, mag_a, mag_b;
    logic neg;
    neg = (a < 0) != (b < 0);
    mag_a = (a < 0) ? 128'(-a) : 128'(a);
    mag_b = (b < 0) ? 128'(-b) : 128'(b);
    prod = (mag_a * mag_b) >> s;
    if (prod > 128'h4000_0000_0000_0000) prod = 128'h4000_0000_0000_0000;
    return neg ? -longint'(prod[63:0]) : longint'(prod[63:0]);
  endfunction

  function longint gain_of(longint num, longint den);
    if (den == 0) return 0;
    return clamp((num * 64'sd268435456) / den);
  endfunction

  function void note_input(kabf_pkg::in_t it);
    longint m_ang, m_rate, dt, rate, qa, qb, rm, pred, dp11, inner;
    longint p00, p01, p10, p11, s, k0, k1, innov;
    kabf_pkg::out_t res;
    m_ang = longint'(it.measured_angle);
    m_rate = longint'(it.measured_rate);
    dt = longint'({40'd0, it.time_step});
    rate = clamp(m_rate - bias_est);
    if (it.kind == kabf_pkg::KIND_SET) begin
      angle_est = m_ang;
    end else begin
      qa = longint'({32'd0, angle_pn >> 4});
      qb = longint'({32'd0, bias_pn >> 4});
      rm = longint'({32'd0, meas_n >> 4});
      pred = clamp(angle_est + mul_shift(rate, dt, 24));
      dp11 = mul_shift(dt, p_bb, 24);
      inner = dp11 - p_ab - p_ba + qa;
      p00 = clamp(p_aa + mul_shift(dt, inner, 24));
      p01 = clamp(p_ab - dp11);
      p10 = clamp(p_ba - dp11);
      p11 = clamp(p_bb + mul_shift(qb, dt, 24));
      s = p00 + rm;
      k0 = gain_of(p00, s);
      k1 = gain_of(p10, s);
      innov = clamp(m_ang - pred);
      angle_est = clamp(pred + mul_shift(k0, innov, 28));
      bias_est = clamp(bias_est + mul_shift(k1, innov, 28));
      p_aa = clamp(p00 - mul_shift(k0, p00, 28));
      p_ab = clamp(p01 - mul_shift(k0, p01, 28));
      p_ba = clamp(p10 - mul_shift(k1, p00, 28));
      p_bb = clamp(p11 - mul_shift(k1, p01, 28));
    end
    res.filtered_angle = angle_est[31:0];
    res.unbiased_rate = rate[31:0];
    res.bias_estimate = bias_est[31:0];
    pending.push_back(res);
  endfunction

  function void check_result(kabf_pkg::out_t got);
    kabf_pkg::out_t want;
    if (pending.size() == 0) begin
      mismatches++;
      if (mismatches <= 10) $display("unexpected result %h", got);
      return;
    end
    want = pending.pop_front();
    if (got !== want) begin
      mismatches++;
      if (mismatches <= 10)
        $display("result mismatch: angle %h/%h rate %h/%h bias %h/%h (exp/act)",
                 want.filtered_angle, got.filtered_angle, want.unbiased_rate,
                 got.unbiased_rate, want.bias_estimate, got.bias_estimate);
    end
  endfunction
endclass

// ===== dv/tb_kalman_angle_bias_filter.sv =====
// Testbench top for the angle/bias Kalman filter.
module tb_kalman_angle_bias_filter;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int UPDATE_LATENCY = 82;
  localparam longint CYCLE_LIMIT = 1500000;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic in_valid_i = 1'b0;
  logic in_ready_o;
  kabf_pkg::in_t in_data_i = '0;
  logic out_valid_o;
  logic out_ready_i = 1'b0;
  kabf_pkg::out_t out_data_o;
  logic cfg_valid_i = 1'b0;
  logic cfg_ready_o;
  logic [kabf_pkg::CFG_IDX_W-1:0] cfg_index_i = '0;
  logic [31:0] cfg_data_i = '0;

  kabf_scoreboard filt_sb;
  longint cycles = 0;
  bit hold_off = 1'b0;

  kalman_angle_bias_filter u_top (.*);

  always #5 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("Mismatches found");
      $finish;
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i) filt_sb.check_result(out_data_o);
  end

  // receiver stall pattern
  initial begin
    int mode;
    forever begin
      @(negedge clk_i);
      if (hold_off) out_ready_i <= 1'b0;
      else begin
        mode = (cycles / 3000) % 3;
        if (mode == 0) out_ready_i <= 1'b1;
        else if (mode == 1) out_ready_i <= ($urandom_range(0, 3) != 0);
        else out_ready_i <= ($urandom_range(0, 9) > 6);
      end
    end
  end

  // valid and payload are set at the falling edge; back-to-back calls reassign them there
  task automatic send_item(kabf_pkg::in_t it);
    in_valid_i = 1'b1;
    in_data_i = it;
    do @(posedge clk_i); while (!in_ready_o);
    filt_sb.note_input(it);
    @(negedge clk_i);
    in_valid_i = 1'b0;
  endtask

  task automatic write_reg(logic [kabf_pkg::CFG_IDX_W-1:0] idx, logic [31:0] val);
    cfg_valid_i = 1'b1;
    cfg_index_i = idx;
    cfg_data_i = val;
    do @(posedge clk_i); while (!cfg_ready_o);
    filt_sb.write_reg(idx, val);
    @(negedge clk_i);
    cfg_valid_i = 1'b0;
  endtask

  task automatic drain();
    while (filt_sb.pending.size() != 0) @(negedge clk_i);
    repeat (UPDATE_LATENCY + 4) @(negedge clk_i);
  endtask

  function automatic kabf_pkg::in_t rand_item(bit tame);
    kabf_pkg::in_t it;
    it.kind = ($urandom_range(0, 15) == 0) ? kabf_pkg::KIND_SET : kabf_pkg::KIND_UPDATE;
    if (tame) begin
      it.measured_angle = $signed($urandom_range(0, 2 * 90 * 65536)) - 90 * 65536;
      it.measured_rate = $signed($urandom_range(0, 2 * 500 * 65536)) - 500 * 65536;
      it.time_step = 24'($urandom_range(0, 50000));
    end else begin
      it.measured_angle = $urandom;
      it.measured_rate = $urandom;
      it.time_step = 24'($urandom);
    end
    return it;
  endfunction

  function automatic kabf_pkg::in_t make_item(logic k, logic [31:0] a, logic [31:0] r,
                                              logic [23:0] t);
    kabf_pkg::in_t it;
    it.kind = k; it.measured_angle = a; it.measured_rate = r; it.time_step = t;
    return it;
  endfunction

  task automatic random_phase(int n);
    int burst;
    while (n > 0) begin
      burst = $urandom_range(1, 20);
      while (burst > 0 && n > 0) begin
        send_item(rand_item($urandom_range(0, 9) != 0));
        burst--; n--;
      end
      repeat ($urandom_range(0, 1) * $urandom_range(1, 120)) @(negedge clk_i);
    end
  endtask

  initial begin
    filt_sb = new();
    filt_sb.reset_state();
    repeat (3) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // directed: extremes, set-angle, zero innovation variance
    send_item(make_item(kabf_pkg::KIND_SET, 32'h8000_0000, 32'h7fff_ffff, 24'hffffff));
    send_item(make_item(kabf_pkg::KIND_UPDATE, 32'h7fff_ffff, 32'h8000_0000, 24'hffffff));
    send_item(make_item(kabf_pkg::KIND_UPDATE, 32'h8000_0000, 32'h7fff_ffff, 24'hffffff));
    send_item(make_item(kabf_pkg::KIND_UPDATE, 32'h0000_0000, 32'h0000_0000, 24'h0));
    send_item(make_item(kabf_pkg::KIND_SET, 32'h00b4_0000, 32'hff4c_0000, 24'h0));
    send_item(make_item(kabf_pkg::KIND_UPDATE, 32'hff4c_0000, 32'h0001_0000, 24'h004189));
    send_item(make_item(kabf_pkg::KIND_UPDATE, 32'hffff_ffff, 32'hffff_ffff, 24'h000001));
    drain();
    write_reg(kabf_pkg::REG_ANGLE_PN, 32'h0);
    write_reg(kabf_pkg::REG_BIAS_PN, 32'h0);
    write_reg(kabf_pkg::REG_MEAS_N, 32'h0);
    send_item(make_item(kabf_pkg::KIND_SET, 32'h0, 32'h0, 24'h0));
    send_item(make_item(kabf_pkg::KIND_UPDATE, 32'h0001_0000, 32'h0, 24'h0));
    send_item(make_item(kabf_pkg::KIND_UPDATE, 32'h7fff_ffff, 32'h7fff_ffff, 24'hffffff));
    drain();
    write_reg(kabf_pkg::REG_ANGLE_PN, 32'hffff_ffff);
    write_reg(kabf_pkg::REG_BIAS_PN, 32'hffff_ffff);
    write_reg(kabf_pkg::REG_MEAS_N, 32'hffff_ffff);
    for (int i = 0; i < 6; i++)
      send_item(make_item(i[0], 32'h8000_0000 ^ {32{i[1]}}, 32'h7fff_ffff ^ {32{i[2]}},
                          24'hffffff));

    // long receiver hold-off while items keep coming
    hold_off = 1'b1;
    fork
      begin repeat (400) @(negedge clk_i); hold_off = 1'b0; end
      random_phase(8);
    join
    drain();

    write_reg(kabf_pkg::REG_ANGLE_PN, kabf_pkg::ANGLE_PN_RST);
    write_reg(kabf_pkg::REG_BIAS_PN, kabf_pkg::BIAS_PN_RST);
    write_reg(kabf_pkg::REG_MEAS_N, kabf_pkg::MEAS_N_RST);
    random_phase(600);
    drain();
    write_reg(kabf_pkg::REG_ANGLE_PN, $urandom);
    write_reg(kabf_pkg::REG_BIAS_PN, $urandom);
    write_reg(kabf_pkg::REG_MEAS_N, $urandom_range(0, 3) == 0 ? 32'h0 : $urandom);
    random_phase(450);
    drain();
    write_reg(kabf_pkg::REG_ANGLE_PN, $urandom_range(0, 65535));
    write_reg(kabf_pkg::REG_BIAS_PN, $urandom_range(0, 65535));
    write_reg(kabf_pkg::REG_MEAS_N, $urandom_range(0, 1 << 28));
    random_phase(470);
    drain();

    if (filt_sb.mismatches == 0 && filt_sb.pending.size() == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end
endmodule
